FILE: sv/pn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_pkg
// Shared constants, codes and controller/datapath interface types for the
// path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

  localparam int PN_BUFFER_SIZE = 256;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  localparam logic [1:0] MODE_BASE = 2'd0;
  localparam logic [1:0] MODE_PATH = 2'd1;
  localparam logic [1:0] MODE_READ = 2'd2;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BUSY     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_DENIED   = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic base_write;
    logic read_latch;
    logic start;
    logic copy_step;
    logic copy_tail;
    logic byte_put;
    logic close;
    logic back_read;
    logic back_dec;
    logic trim;
    logic emit;
  } pn_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] mode;
    logic       last;
    logic       is_slash;
    logic       is_zero;
    logic       in_path;
    logic       err_ok;
    logic       start_copy;
    logic       copy_done;
    logic       close_back;
    logic       wp_zero;
    logic       back_q_slash;
    logic       out_free;
  } pn_stat_t;

endpackage

FILE: sv/pn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/pn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_ctrl
// Sequencer for the path normalizer: takes one item at a time, stores base
// bytes and result reads, steps the datapath through base copy, component
// close, '..' back-up and trim, and hands the result to the output register.
// ----------------------------------------------------------------------------
module pn_ctrl
  import pn_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  pn_stat_t st,
  output pn_cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE     = 10'b0000000001,
    S_DISPATCH = 10'b0000000010,
    S_READ     = 10'b0000000100,
    S_COPY     = 10'b0000001000,
    S_BYTE     = 10'b0000010000,
    S_LAST     = 10'b0000100000,
    S_BACK_RD  = 10'b0001000000,
    S_BACK_CHK = 10'b0010000000,
    S_TRIM     = 10'b0100000000,
    S_EMIT     = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   last_close, last_close_next;
  logic   byte_go;
  state_t route_back;

  assign in_stall = (state != S_IDLE);

  // where to continue once a '..' back-up has finished
  assign route_back = last_close ? S_TRIM : (st.last ? S_LAST : S_EMIT);

  always_comb begin
    state_next      = state;
    last_close_next = last_close;
    cmd             = '0;
    byte_go         = 1'b0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (st.mode)
          MODE_BASE: begin
            cmd.base_write = 1'b1;
            state_next     = S_EMIT;
          end
          MODE_PATH: begin
            if (st.in_path) begin
              byte_go = 1'b1;
            end else begin
              cmd.start  = 1'b1;
              state_next = st.start_copy ? S_COPY : S_BYTE;
            end
          end
          MODE_READ: state_next = S_READ;
          default:   state_next = S_EMIT;
        endcase
      end
      S_READ: begin
        cmd.read_latch = 1'b1;
        state_next     = S_EMIT;
      end
      S_COPY: begin
        if (st.copy_done) begin
          cmd.copy_tail = 1'b1;
          state_next    = S_BYTE;
        end else begin
          cmd.copy_step = 1'b1;
        end
      end
      S_BYTE: byte_go = 1'b1;
      S_LAST: begin
        state_next = S_TRIM;
        if (st.err_ok) begin
          cmd.close = 1'b1;
          if (st.close_back) begin
            last_close_next = 1'b1;
            state_next      = S_BACK_RD;
          end
        end
      end
      S_BACK_RD: begin
        if (st.wp_zero) begin
          state_next = route_back;
        end else begin
          cmd.back_read = 1'b1;
          state_next    = S_BACK_CHK;
        end
      end
      S_BACK_CHK: begin
        if (st.back_q_slash) begin
          state_next = route_back;
        end else begin
          cmd.back_dec = 1'b1;
          state_next   = S_BACK_RD;
        end
      end
      S_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    // one path byte: store it or close the component it ends
    if (byte_go) begin
      state_next = st.last ? S_LAST : S_EMIT;
      if (st.err_ok && !st.is_zero) begin
        if (st.is_slash) begin
          cmd.close = 1'b1;
          if (st.close_back) begin
            last_close_next = 1'b0;
            state_next      = S_BACK_RD;
          end
        end else begin
          cmd.byte_put = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      last_close <= 1'b0;
    end else begin
      state      <= state_next;
      last_close <= last_close_next;
    end
  end

endmodule

FILE: sv/pn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_datapath
// Item register, path state, base and result stores and the output
// register of the path normalizer.
// ----------------------------------------------------------------------------
module pn_datapath
  import pn_pkg::*;
#(
  parameter int BUFFER_SIZE = PN_BUFFER_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  pn_cmd_t    cmd,
  output pn_stat_t   st,
  input  logic [1:0] mode,
  input  logic [7:0] char_in,
  input  logic       last,
  input  logic [7:0] index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] length,
  output logic [7:0] read_char,
  output logic       done_res
);

  localparam int AW = $clog2(BUFFER_SIZE);
  localparam int PW = $clog2(BUFFER_SIZE + 1);
  localparam int SW = PW + 1;
  localparam int CW = (PW > 8) ? PW : 8;

  // captured item
  logic [1:0] it_mode;
  logic [7:0] it_char;
  logic       it_last;
  logic [7:0] it_index;

  // path and base state
  logic [PW-1:0] base_length;
  logic          base_closed;
  logic          base_last_slash;
  logic [PW-1:0] wp;
  logic [PW-1:0] cl;
  logic          in_path;
  status_t       err;
  logic [7:0]    comp_first;
  logic [7:0]    comp_second;
  logic [PW-1:0] copy_rd;
  logic [PW-1:0] copy_wr;
  logic          copy_pend;
  logic [7:0]    rd_char;

  // output register
  status_t    out_status;
  logic [7:0] out_length;
  logic [7:0] out_read_char;
  logic       out_done;

  // store ports
  logic          base_we;
  logic [AW-1:0] base_waddr;
  logic [7:0]    base_q;
  logic          res_we;
  logic [AW-1:0] res_waddr;
  logic [7:0]    res_wdata;
  logic [AW-1:0] res_raddr;
  logic [7:0]    res_q;

  logic [PW-1:0] bl_eff;
  logic          base_store_ok;
  logic [SW-1:0] sum_wc;
  logic          byte_fits;
  logic          close_over;
  logic          comp_empty;
  logic          comp_dot;
  logic          comp_dotdot;
  logic [PW-1:0] wp_m1;
  logic [PW-1:0] wp_trim;
  logic          read_hit;
  status_t       status_now;
  logic [CW-1:0] wp_c;
  logic [7:0]    length_now;

  assign bl_eff        = base_closed ? '0 : base_length;
  assign base_store_ok = (it_char != CHAR_NUL) && (SW'(bl_eff) < SW'(BUFFER_SIZE - 1));
  assign base_we       = cmd.base_write && base_store_ok;
  assign base_waddr    = bl_eff[AW-1:0];

  assign sum_wc      = SW'(wp) + SW'(cl);
  assign byte_fits   = sum_wc < SW'(BUFFER_SIZE);
  assign close_over  = (sum_wc + SW'(1)) > SW'(BUFFER_SIZE);
  assign comp_empty  = (cl == '0);
  assign comp_dot    = (cl == PW'(1)) && (comp_first == CHAR_DOT);
  assign comp_dotdot = (cl == PW'(2)) && (comp_first == CHAR_DOT) && (comp_second == CHAR_DOT);
  assign wp_m1       = wp - PW'(1);
  assign wp_trim     = (wp > PW'(1)) ? wp_m1 : wp;
  assign read_hit    = (CW'(it_index) < CW'(wp)) && (CW'(it_index) < CW'(BUFFER_SIZE));

  assign res_raddr = cmd.back_read ? wp_m1[AW-1:0] : AW'(it_index);

  always_comb begin
    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = CHAR_SLASH;
    if (cmd.start) begin
      res_we = (it_char == CHAR_SLASH);
    end else if (cmd.copy_step) begin
      res_we    = copy_pend;
      res_waddr = copy_wr[AW-1:0];
      res_wdata = base_q;
    end else if (cmd.copy_tail) begin
      res_we    = !base_last_slash;
      res_waddr = base_length[AW-1:0];
    end else if (cmd.byte_put) begin
      res_we    = byte_fits;
      res_waddr = sum_wc[AW-1:0];
      res_wdata = it_char;
    end else if (cmd.close) begin
      // an ordinary component gets its '/' right behind it
      res_we    = !comp_empty && !comp_dot && !comp_dotdot && !close_over;
      res_waddr = sum_wc[AW-1:0];
    end
  end

  pn_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_SIZE)
  ) u_base_ram (
    .clk   (clk),
    .we    (base_we),
    .waddr (base_waddr),
    .wdata (it_char),
    .raddr (copy_rd[AW-1:0]),
    .rdata (base_q)
  );

  pn_ram #(
    .WIDTH (8),
    .DEPTH (BUFFER_SIZE)
  ) u_result_ram (
    .clk   (clk),
    .we    (res_we),
    .waddr (res_waddr),
    .wdata (res_wdata),
    .raddr (res_raddr),
    .rdata (res_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      base_length     <= '0;
      base_closed     <= 1'b0;
      base_last_slash <= 1'b0;
      wp              <= '0;
      cl              <= '0;
      in_path         <= 1'b0;
      err             <= ST_OK;
      copy_rd         <= '0;
      copy_wr         <= '0;
      copy_pend       <= 1'b0;
    end else begin
      if (cmd.base_write) begin
        base_closed <= it_last;
        if (base_store_ok) begin
          base_length     <= bl_eff + PW'(1);
          base_last_slash <= (it_char == CHAR_SLASH);
        end else begin
          base_length <= bl_eff;
        end
      end

      if (cmd.start) begin
        in_path   <= 1'b1;
        err       <= (it_char == CHAR_NUL) ? ST_NOTFOUND : ST_OK;
        cl        <= '0;
        copy_rd   <= '0;
        copy_wr   <= '0;
        copy_pend <= 1'b0;
        wp        <= (it_char == CHAR_SLASH) ? PW'(1) : '0;
      end

      if (cmd.copy_step) begin
        if (copy_rd < base_length) begin
          copy_rd   <= copy_rd + PW'(1);
          copy_pend <= 1'b1;
        end else begin
          copy_pend <= 1'b0;
        end
        if (copy_pend) begin
          copy_wr <= copy_wr + PW'(1);
        end
      end

      if (cmd.copy_tail) begin
        wp <= base_last_slash ? base_length : base_length + PW'(1);
      end

      if (cmd.byte_put) begin
        if (cl == '0) begin
          comp_first <= it_char;
        end else if (cl == PW'(1)) begin
          comp_second <= it_char;
        end
        if (cl < PW'(BUFFER_SIZE)) begin
          cl <= cl + PW'(1);
        end
      end

      if (cmd.close) begin
        cl <= '0;
        if (comp_dotdot) begin
          // the root stays put, an empty relative buffer is denied
          if (wp == '0) begin
            err <= ST_DENIED;
          end else if (wp != PW'(1)) begin
            wp <= wp_m1;
          end
        end else if (!comp_empty && !comp_dot) begin
          if (close_over) begin
            err <= ST_TOOLONG;
            wp  <= '0;
          end else begin
            wp <= PW'(sum_wc + SW'(1));
          end
        end
      end

      if (cmd.back_dec) begin
        wp <= wp_m1;
      end

      if (cmd.trim) begin
        in_path <= 1'b0;
        cl      <= '0;
        if (err == ST_OK) begin
          if (SW'(wp_trim) >= SW'(BUFFER_SIZE)) begin
            err <= ST_TOOLONG;
            wp  <= '0;
          end else begin
            wp <= wp_trim;
          end
        end
      end
    end
  end

  // item register and read data
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      it_mode  <= mode;
      it_char  <= char_in;
      it_last  <= last;
      it_index <= index;
      rd_char  <= CHAR_NUL;
    end else if (cmd.read_latch) begin
      rd_char <= read_hit ? res_q : CHAR_NUL;
    end
  end

  assign status_now = (in_path && err == ST_OK) ? ST_BUSY : err;
  assign wp_c       = CW'(wp);
  assign length_now = (wp_c > CW'(255)) ? 8'hFF : wp_c[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status    <= status_now;
      out_length    <= length_now;
      out_read_char <= rd_char;
      out_done      <= (it_mode == MODE_PATH) && it_last;
    end
  end

  assign status    = out_status;
  assign length    = out_length;
  assign read_char = out_read_char;
  assign done_res  = out_done;

  assign st.mode         = it_mode;
  assign st.last         = it_last;
  assign st.is_slash     = (it_char == CHAR_SLASH);
  assign st.is_zero      = (it_char == CHAR_NUL);
  assign st.in_path      = in_path;
  assign st.err_ok       = (err == ST_OK);
  assign st.start_copy   = (it_char != CHAR_SLASH) && (it_char != CHAR_NUL) &&
                           (base_length != '0);
  assign st.copy_done    = (copy_wr == base_length);
  assign st.close_back   = comp_dotdot && (wp > PW'(1));
  assign st.wp_zero      = (wp == '0);
  assign st.back_q_slash = (res_q == CHAR_SLASH);
  assign st.out_free     = !out_valid || !out_stall;

endmodule

FILE: sv/path_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// path_normalizer
// Canonicalizes one path streamed a byte per item against a loaded base
// directory; results are read back a byte per item.
// ----------------------------------------------------------------------------
// One item is taken at a time and each gives one result item. The first
// byte of a relative path also copies the base into the result store
// through its single write port. A final byte adds a closing pass and a
// trailing-slash trim, and every byte that a '..' removes takes one result
// store read and one compare per step. The output register holds a
// finished result while the next item is already taken. Store contents
// need no clearing after reset, so the block takes items as soon as reset
// is released.
// ----------------------------------------------------------------------------
module path_normalizer
  import pn_pkg::*;
#(
  parameter int BUFFER_SIZE = PN_BUFFER_SIZE
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] char_in,
  input  logic       last,
  input  logic [7:0] index,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] status,
  output logic [7:0] length,
  output logic [7:0] read_char,
  output logic       done_res
);

  pn_cmd_t  cmd;
  pn_stat_t st;

  pn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  pn_datapath #(
    .BUFFER_SIZE (BUFFER_SIZE)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .mode      (mode),
    .char_in   (char_in),
    .last      (last),
    .index     (index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .length    (length),
    .read_char (read_char),
    .done_res  (done_res)
  );

endmodule

FILE: sv/pn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pn_checker
// Port-level checks for the path normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module pn_checker
  import pn_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] status,
  input logic [7:0] length,
  input logic [7:0] read_char,
  input logic       done_res
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(length) &&
                               $stable(read_char) && $stable(done_res))
    else $error("stalled result changed");

  // one item at a time: the cycle after an accept is busy
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while an item is in work");

  // a finished path never reports in progress
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> status != ST_BUSY)
    else $error("completed path still busy");

  // a latched error leaves an empty result
  a_err_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NOTFOUND || status == ST_DENIED || status == ST_TOOLONG)
    |-> length == 8'd0)
    else $error("error with nonzero length");

  // a read byte can only come from a nonempty result
  a_read_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && read_char != 8'd0 |-> length != 8'd0)
    else $error("read byte beyond result length");

endmodule

bind path_normalizer pn_checker u_pn_checker (.*);
